// ===== hw/rtl/brcf_pkg.sv =====
// Package with the word types, register indexes and code constants of the remap block.
package brcf_pkg;

  // Input word.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] buttons;
    logic [31:0] now_ms;
    logic [2:0]  slot_index;
    logic [31:0] slot_mask;
  } in_t;

  // Result word.
  typedef struct packed {
    logic       remap_active;
    logic [5:0] mapped_out;
    logic [2:0] mode_code;
    logic       entered_remap;
    logic       duplicate_press;
    logic       timed_out_flag;
    logic       completed_flag;
  } out_t;

  // Action codes of the input word.
  localparam logic [1:0] ACT_CONNECT    = 2'd0;
  localparam logic [1:0] ACT_FRAME      = 2'd1;
  localparam logic [1:0] ACT_SLOT_WRITE = 2'd2;

  // Mode codes as reported in the result word.
  localparam logic [2:0] MCODE_IDLE       = 3'd0;
  localparam logic [2:0] MCODE_HOLDING    = 3'd1;
  localparam logic [2:0] MCODE_WAITING    = 3'd2;
  localparam logic [2:0] MCODE_COLLECTING = 3'd3;
  localparam logic [2:0] MCODE_DONE       = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_HOLD_TIME     = 3'd0;
  localparam logic [2:0] REG_IDLE_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_BOOT_WINDOW   = 3'd2;
  localparam logic [2:0] REG_COMBO_MASK    = 3'd3;
  localparam logic [2:0] REG_SELECT_MASK   = 3'd4;
  localparam logic [2:0] REG_START_MASK    = 3'd5;
  localparam logic [2:0] REG_LOCKED_MASK   = 3'd6;

  // Register reset values.
  localparam logic [15:0] HOLD_TIME_RST    = 16'd2000;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] BOOT_WINDOW_RST  = 16'd5000;

  // Remap state machine, one-hot.
  typedef enum logic [4:0] {
    MODE_IDLE       = 5'b00001,
    MODE_HOLDING    = 5'b00010,
    MODE_WAITING    = 5'b00100,
    MODE_COLLECTING = 5'b01000,
    MODE_DONE       = 5'b10000
  } mode_t;

endpackage

// ===== hw/rtl/button_remap_capture_fsm_top.sv =====
// Button remap capture machine: state update, active table and result buffer.
// Output: a result word is registered in the head register, or in the skid entry while the head is stalled.
// Throughput: one word per cycle while the skid entry is free; the whole update is one pass of logic into the
// result register, and a two-entry result buffer keeps input open while a result waits.
// Reset: synchronous, active low; registers return to their defaults, both tables
// clear, the machine goes idle and the result buffer empties.
module button_remap_capture_fsm_top #(
  parameter int SLOT_COUNT  = 6,
  parameter int BUTTON_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brcf_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output brcf_pkg::out_t      out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int SF_W  = $clog2(SLOT_COUNT + 1);
  localparam int MAP_N = (SLOT_COUNT < 6) ? SLOT_COUNT : 6;

  // Configuration registers.
  logic [15:0] hold_time_r, idle_timeout_r, boot_window_r;
  logic [31:0] combo_mask_r, select_mask_r, start_mask_r, locked_mask_r;

  // Machine state.
  brcf_pkg::mode_t        mode_r, mode_nxt;
  logic                   boot_closed_r, boot_closed_nxt;
  logic [31:0]            connect_time_r, connect_time_nxt;
  logic [31:0]            last_act_r, last_act_nxt;
  logic [31:0]            held_trig_r, held_trig_nxt;
  logic [BUTTON_BITS-1:0] prev_btn_r, prev_btn_nxt;
  logic [SF_W-1:0]        slots_filled_r, slots_filled_nxt;
  logic [BUTTON_BITS-1:0] assigned_r, assigned_nxt;
  logic [BUTTON_BITS-1:0] pending_r [SLOT_COUNT];
  logic [BUTTON_BITS-1:0] pending_nxt [SLOT_COUNT];
  logic [BUTTON_BITS-1:0] active_r [SLOT_COUNT];
  logic [BUTTON_BITS-1:0] active_nxt [SLOT_COUNT];
  logic                   timed_out_r, timed_out_nxt;
  logic                   completed_r, completed_nxt;

  // Result buffer: head register and one skid entry.
  brcf_pkg::out_t out_r, skid_r, res;
  logic           out_valid_r, skid_valid_r;

  // Working values for the current word.
  logic                   push, pop;
  logic [BUTTON_BITS-1:0] b, smask, fresh;
  logic [31:0]            bx, dt_act, dt_conn, trig;
  logic                   fresh_single;
  logic                   active_flag, entered_flag, dup_flag;
  logic [5:0]             mapped;

  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign b       = in_data.buttons[BUTTON_BITS-1:0];
  assign smask   = in_data.slot_mask[BUTTON_BITS-1:0];
  assign bx      = 32'(b);
  assign dt_act  = in_data.now_ms - last_act_r;
  assign dt_conn = in_data.now_ms - connect_time_r;
  assign fresh   = b & ~prev_btn_r;
  assign fresh_single = (fresh != '0) && ((fresh & (fresh - BUTTON_BITS'(1))) == '0);

  // Trigger detection in idle: combo first, then select alone, then start alone.
  always_comb begin
    trig = '0;
    if (combo_mask_r != '0 && (bx & combo_mask_r) == combo_mask_r) begin
      trig = combo_mask_r;
    end else if ((bx & select_mask_r) != '0 && (bx & ~select_mask_r) == '0) begin
      trig = select_mask_r;
    end else if ((bx & start_mask_r) != '0 && (bx & ~start_mask_r) == '0) begin
      trig = start_mask_r;
    end
  end

  // Next state of the remap machine and the tables.
  always_comb begin
    mode_nxt         = mode_r;
    boot_closed_nxt  = boot_closed_r;
    connect_time_nxt = connect_time_r;
    last_act_nxt     = last_act_r;
    held_trig_nxt    = held_trig_r;
    prev_btn_nxt     = prev_btn_r;
    slots_filled_nxt = slots_filled_r;
    assigned_nxt     = assigned_r;
    timed_out_nxt    = timed_out_r;
    completed_nxt    = completed_r;
    pending_nxt      = pending_r;
    active_nxt       = active_r;
    active_flag      = 1'b0;
    entered_flag     = 1'b0;
    dup_flag         = 1'b0;

    case (in_data.action)
      // A connect clears the session but keeps the active table.
      brcf_pkg::ACT_CONNECT: begin
        mode_nxt         = brcf_pkg::MODE_IDLE;
        boot_closed_nxt  = 1'b0;
        connect_time_nxt = in_data.now_ms;
        last_act_nxt     = '0;
        held_trig_nxt    = '0;
        prev_btn_nxt     = '0;
        slots_filled_nxt = '0;
        assigned_nxt     = '0;
        timed_out_nxt    = 1'b0;
        completed_nxt    = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          pending_nxt[i] = '0;
        end
      end

      // Direct write of one active table slot; slots past the table are dropped.
      brcf_pkg::ACT_SLOT_WRITE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (in_data.slot_index == 3'(i)) begin
            active_nxt[i] = smask;
          end
        end
      end

      brcf_pkg::ACT_FRAME: begin
        case (mode_r)
          brcf_pkg::MODE_IDLE: begin
            if (!boot_closed_r) begin
              if (trig != '0) begin
                mode_nxt      = brcf_pkg::MODE_HOLDING;
                last_act_nxt  = in_data.now_ms;
                held_trig_nxt = trig;
              end else if (dt_conn > 32'(boot_window_r)) begin
                boot_closed_nxt = 1'b1;
              end
            end
          end

          brcf_pkg::MODE_HOLDING: begin
            if ((bx & held_trig_r) != held_trig_r) begin
              mode_nxt        = brcf_pkg::MODE_IDLE;
              boot_closed_nxt = 1'b1;
              held_trig_nxt   = '0;
            end else if (dt_act >= 32'(hold_time_r)) begin
              mode_nxt         = brcf_pkg::MODE_WAITING;
              last_act_nxt     = in_data.now_ms;
              slots_filled_nxt = '0;
              assigned_nxt     = '0;
              for (int i = 0; i < SLOT_COUNT; i++) begin
                pending_nxt[i] = '0;
              end
              active_flag  = 1'b1;
              entered_flag = 1'b1;
            end
          end

          brcf_pkg::MODE_WAITING: begin
            if (dt_act > 32'(idle_timeout_r)) begin
              mode_nxt        = brcf_pkg::MODE_IDLE;
              boot_closed_nxt = 1'b1;
              timed_out_nxt   = 1'b1;
            end else begin
              if ((bx & held_trig_r) == '0) begin
                mode_nxt     = brcf_pkg::MODE_COLLECTING;
                prev_btn_nxt = '0;
                last_act_nxt = in_data.now_ms;
                assigned_nxt = '0;
              end
              active_flag = 1'b1;
            end
          end

          brcf_pkg::MODE_COLLECTING: begin
            if (dt_act > 32'(idle_timeout_r)) begin
              mode_nxt        = brcf_pkg::MODE_IDLE;
              boot_closed_nxt = 1'b1;
              timed_out_nxt   = 1'b1;
            end else begin
              active_flag  = 1'b1;
              prev_btn_nxt = b;
              // Only a single new, unlocked press counts.
              if (fresh_single && (32'(fresh) & locked_mask_r) == '0) begin
                last_act_nxt = in_data.now_ms;
                if ((fresh & assigned_r) != '0) begin
                  dup_flag = 1'b1;
                end else begin
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (slots_filled_r == SF_W'(i)) begin
                      pending_nxt[i] = fresh;
                    end
                  end
                  assigned_nxt     = assigned_r | fresh;
                  slots_filled_nxt = slots_filled_r + SF_W'(1);
                  // Last slot captured: commit the pending table.
                  if (slots_filled_r == SF_W'(SLOT_COUNT - 1)) begin
                    active_nxt    = pending_nxt;
                    completed_nxt = 1'b1;
                    mode_nxt      = brcf_pkg::MODE_DONE;
                  end
                end
              end
            end
          end

          default: begin
            mode_nxt        = brcf_pkg::MODE_IDLE;
            boot_closed_nxt = 1'b1;
          end
        endcase
      end

      default: begin
      end
    endcase
  end

  // Mapped output from the updated active table, frames only.
  always_comb begin
    mapped = '0;
    if (in_data.action == brcf_pkg::ACT_FRAME) begin
      for (int i = 0; i < MAP_N; i++) begin
        mapped[i] = (b & active_nxt[i]) != '0;
      end
    end
  end

  // Assemble the result word.
  always_comb begin
    res.remap_active    = active_flag;
    res.mapped_out      = mapped;
    res.entered_remap   = entered_flag;
    res.duplicate_press = dup_flag;
    res.timed_out_flag  = timed_out_nxt;
    res.completed_flag  = completed_nxt;
    case (mode_nxt)
      brcf_pkg::MODE_IDLE:       res.mode_code = brcf_pkg::MCODE_IDLE;
      brcf_pkg::MODE_HOLDING:    res.mode_code = brcf_pkg::MCODE_HOLDING;
      brcf_pkg::MODE_WAITING:    res.mode_code = brcf_pkg::MCODE_WAITING;
      brcf_pkg::MODE_COLLECTING: res.mode_code = brcf_pkg::MCODE_COLLECTING;
      brcf_pkg::MODE_DONE:       res.mode_code = brcf_pkg::MCODE_DONE;
      default:                   res.mode_code = brcf_pkg::MCODE_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r    <= brcf_pkg::HOLD_TIME_RST;
      idle_timeout_r <= brcf_pkg::IDLE_TIMEOUT_RST;
      boot_window_r  <= brcf_pkg::BOOT_WINDOW_RST;
      combo_mask_r   <= '0;
      select_mask_r  <= '0;
      start_mask_r   <= '0;
      locked_mask_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        brcf_pkg::REG_HOLD_TIME:    hold_time_r    <= cfg_data[15:0];
        brcf_pkg::REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data[15:0];
        brcf_pkg::REG_BOOT_WINDOW:  boot_window_r  <= cfg_data[15:0];
        brcf_pkg::REG_COMBO_MASK:   combo_mask_r   <= cfg_data;
        brcf_pkg::REG_SELECT_MASK:  select_mask_r  <= cfg_data;
        brcf_pkg::REG_START_MASK:   start_mask_r   <= cfg_data;
        brcf_pkg::REG_LOCKED_MASK:  locked_mask_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Machine state registers, updated on every accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= brcf_pkg::MODE_IDLE;
      boot_closed_r  <= 1'b0;
      connect_time_r <= '0;
      last_act_r     <= '0;
      held_trig_r    <= '0;
      prev_btn_r     <= '0;
      slots_filled_r <= '0;
      assigned_r     <= '0;
      timed_out_r    <= 1'b0;
      completed_r    <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pending_r[i] <= '0;
        active_r[i]  <= '0;
      end
    end else if (push) begin
      mode_r         <= mode_nxt;
      boot_closed_r  <= boot_closed_nxt;
      connect_time_r <= connect_time_nxt;
      last_act_r     <= last_act_nxt;
      held_trig_r    <= held_trig_nxt;
      prev_btn_r     <= prev_btn_nxt;
      slots_filled_r <= slots_filled_nxt;
      assigned_r     <= assigned_nxt;
      timed_out_r    <= timed_out_nxt;
      completed_r    <= completed_nxt;
      pending_r      <= pending_nxt;
      active_r       <= active_nxt;
    end
  end

  // Two-entry result buffer; the skid entry fills only while the head is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
        if (push) begin
          out_r <= res;
        end
      end
    end else if (push) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  // The skid entry is never occupied while the head is empty.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a word while the head is empty");

  // An accepted word leaves the head register holding a valid word, its own or an older one.
  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("accepted word did not reach the result register");

  // Entering remap is only reported together with the waiting mode and active flag.
  a_entered_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.entered_remap) |->
      (out_r.remap_active && out_r.mode_code == brcf_pkg::MCODE_WAITING))
    else $error("entered_remap reported outside the waiting mode");

  // A duplicate press leaves the machine collecting.
  a_dup_collecting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.duplicate_press) |->
      (out_r.remap_active && out_r.mode_code == brcf_pkg::MCODE_COLLECTING))
    else $error("duplicate press reported outside the collecting mode");
`endif

endmodule
